// ===== design/ult_pkg.sv =====
// Package for the unordered list table: sizes, field layout, command and status codes.
// Used by unordered_list_table_core. It has no dependencies.
`timescale 1ns / 1ps

package ult_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int CMD_W      = 3;
  localparam int VALUE_W    = 16;
  localparam int STAT_W     = 2;
  localparam int LEN_W      = 5;

  localparam int IN_FIELD_W  = CMD_W + VALUE_W;
  localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = STAT_W + 1 + VALUE_W + LEN_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REWIND = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_EMPTY  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_END       = 2'd3;

endpackage

// ===== design/ult_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
// Self-contained; instantiated by unordered_list_table_core.
`timescale 1ns / 1ps

module ult_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/unordered_list_table_core.sv =====
// Unordered list table top level: command sequencer, one compare unit, entry RAM.
// Depends on ult_pkg and ult_ram.
//
//   channel | bus                          | item
//   --------+------------------------------+-------------------------------------------
//   in      | in_tvalid/in_tready/in_tdata | command, item_value
//   out     | out_tvalid/out_tready/out_tdata | status, found, result_value, list_length
//
// Entries sit in RAM oldest first, so put is one write and the newest is at the top.
// Put, rewind and empty go from idle straight to emit; next first reads the RAM in S_NEXT.
// Find and delete scan from the newest entry, one compare per cycle;
// delete then moves the newer entries down, one per cycle.
// Reset clears the state, count, cursor, started flag and output valid only; RAM contents are not cleared.
// The input stalls while a command runs and while its result waits for the output register.
`timescale 1ns / 1ps

module unordered_list_table_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ult_pkg::IN_DATA_W-1:0]  in_tdata,   // command[2:0], item_value[18:3]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ult_pkg::OUT_DATA_W-1:0] out_tdata   // status[1:0], found[2],
                                                     // result_value[18:3], list_length[23:19]
);

  import ult_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_NEXT   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    cursor_r, cursor_nxt;
  logic                started_r, started_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic                res_found_r, res_found_nxt;
  logic [VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                ram_wr_en;
  logic [IDX_W-1:0]    ram_wr_addr;
  logic [VALUE_W-1:0]  ram_wr_data;
  logic                ram_rd_en;
  logic [IDX_W-1:0]    ram_rd_addr;
  logic [VALUE_W-1:0]  ram_rd_data;

  logic [CMD_W-1:0]    in_cmd;
  logic [VALUE_W-1:0]  in_val;
  logic [CNT_W-1:0]    count_m1;
  logic [CNT_W-1:0]    next_pos;
  logic [CNT_W-1:0]    next_phys;
  logic [CNT_W-1:0]    shift_src;
  logic [CNT_W-1:0]    idx_p1;
  logic                hit;

  ult_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (LIST_DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign in_cmd    = in_tdata[CMD_W-1:0];
  assign in_val    = in_tdata[CMD_W +: VALUE_W];
  assign count_m1  = count_r - CNT_W'(1);
  assign next_pos  = started_r ? (CNT_W'(cursor_r) + CNT_W'(1)) : '0;
  assign next_phys = count_m1 - next_pos;
  assign shift_src = CNT_W'(idx_r) + CNT_W'(2);
  assign idx_p1    = CNT_W'(idx_r) + CNT_W'(1);
  assign hit       = (ram_rd_data == val_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    started_nxt    = started_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = idx_r;
    ram_wr_data    = val_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = in_cmd;
          val_nxt        = in_val;
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          res_value_nxt  = '0;
          state_nxt      = S_EMIT;
          unique case (in_cmd)
            CMD_PUT: begin
              cursor_nxt  = '0;
              started_nxt = 1'b0;
              if (count_r < CNT_W'(LIST_DEPTH)) begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = count_r[IDX_W-1:0];
                ram_wr_data = in_val;
                count_nxt   = count_r + CNT_W'(1);
              end else begin
                res_status_nxt = ST_FULL;
              end
            end
            CMD_DELETE, CMD_FIND: begin
              if (in_cmd == CMD_DELETE) begin
                cursor_nxt  = '0;
                started_nxt = 1'b0;
              end
              if (count_r == '0) begin
                if (in_cmd == CMD_DELETE) begin
                  res_status_nxt = ST_NOT_FOUND;
                end
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = count_m1[IDX_W-1:0];
                idx_nxt     = count_m1[IDX_W-1:0];
                state_nxt   = S_SEARCH;
              end
            end
            CMD_REWIND: begin
              cursor_nxt  = '0;
              started_nxt = 1'b0;
            end
            CMD_NEXT: begin
              if (next_pos < count_r) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = next_phys[IDX_W-1:0];
                cursor_nxt  = next_pos[IDX_W-1:0];
                started_nxt = 1'b1;
                state_nxt   = S_NEXT;
              end else begin
                res_status_nxt = ST_END;
              end
            end
            CMD_EMPTY: begin
              count_nxt   = '0;
              cursor_nxt  = '0;
              started_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          if (cmd_r == CMD_FIND) begin
            res_value_nxt = ram_rd_data;
            state_nxt     = S_EMIT;
          end else if (idx_p1 == count_r) begin
            count_nxt = count_m1;
            state_nxt = S_EMIT;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_p1[IDX_W-1:0];
            state_nxt   = S_SHIFT;
          end
        end else if (idx_r == '0) begin
          if (cmd_r == CMD_DELETE) begin
            res_status_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_EMIT;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_r - IDX_W'(1);
          idx_nxt     = idx_r - IDX_W'(1);
        end
      end

      S_SHIFT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r;
        ram_wr_data = ram_rd_data;
        if (shift_src == count_r) begin
          count_nxt = count_m1;
          state_nxt = S_EMIT;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = shift_src[IDX_W-1:0];
          idx_nxt     = idx_p1[IDX_W-1:0];
        end
      end

      S_NEXT: begin
        res_value_nxt = ram_rd_data;
        state_nxt     = S_EMIT;
      end

      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_DATA_W'({LEN_W'(count_r), res_value_r, res_found_r, res_status_r});
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      cursor_r     <= '0;
      started_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      cursor_r     <= cursor_nxt;
      started_r    <= started_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

endmodule
